@@ design/rlpst_pkg.sv @@
// Shared types, codes and constants for the RLP stream tokenizer.
// No dependencies; every other design file but rlpst_ram refers to this package by scoped names.
`default_nettype none

package rlpst_pkg;

    // Field widths of the input and result beats.
    localparam int DATA_W   = 8;
    localparam int KIND_W   = 3;
    localparam int LEVEL_W  = 4;
    localparam int LEN_W    = 32;
    localparam int CLOSED_W = 4;
    localparam int ERR_W    = 3;

    // Width of a long-header length-byte count (one to eight).
    localparam int NB_W = 4;

    // Default limits, handed down from the top level.
    localparam int DEF_MAX_DEPTH     = 8;
    localparam int DEF_MAX_LEN_BYTES = 4;

    // Prefix byte boundaries.
    localparam logic [DATA_W-1:0] STR_BASE        = 8'd128;
    localparam logic [DATA_W-1:0] LIST_BASE       = 8'd192;
    localparam logic [DATA_W-1:0] SHORT_MAX       = 8'd55;
    localparam logic [DATA_W-1:0] STR_SHORT_LAST  = STR_BASE + SHORT_MAX;
    localparam logic [DATA_W-1:0] LIST_SHORT_LAST = LIST_BASE + SHORT_MAX;

    // Saturation limit of the level and close counts.
    localparam logic [LEVEL_W-1:0] SAT_MAX = 4'd15;

    typedef enum logic [KIND_W-1:0] {
        KIND_SINGLE     = 3'd0,
        KIND_SHORT_STR  = 3'd1,
        KIND_LONG_STR   = 3'd2,
        KIND_SHORT_LIST = 3'd3,
        KIND_LONG_LIST  = 3'd4,
        KIND_LEN_BYTE   = 3'd5,
        KIND_PAYLOAD    = 3'd6
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_DEEP    = 3'd1,
        ERR_LONGLEN = 3'd2,
        ERR_OVERRUN = 3'd3,
        ERR_EARLY   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_POP   = 2'd2,
        ST_FETCH = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic pop;
        logic emit;
        logic load_top;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_hit;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ design/rlpst_if.sv @@
// Valid/ready channel interfaces for the byte input and the token result.
// Depends on rlpst_pkg for the field widths.
`default_nettype none

interface rlpst_in_if;
    logic                        valid;
    logic                        ready;
    logic [rlpst_pkg::DATA_W-1:0] data_byte;
    logic                        message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface rlpst_out_if;
    logic                          valid;
    logic                          ready;
    logic [rlpst_pkg::KIND_W-1:0]   byte_kind;
    logic [rlpst_pkg::LEVEL_W-1:0]  nest_level;
    logic [rlpst_pkg::LEN_W-1:0]    item_length;
    logic                          length_valid;
    logic [rlpst_pkg::CLOSED_W-1:0] lists_closed;
    logic [rlpst_pkg::ERR_W-1:0]    error_code;
    logic                          end_seen;

    modport source (output valid, output byte_kind, output nest_level, output item_length,
                    output length_valid, output lists_closed, output error_code,
                    output end_seen, input ready);
    modport sink   (input valid, input byte_kind, input nest_level, input item_length,
                    input length_valid, input lists_closed, input error_code,
                    input end_seen, output ready);
endinterface

`default_nettype wire

@@ design/rlpst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rlpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/rlpst_ctrl.sv @@
// Sequencing state machine of the tokenizer: capture, execute, stack pop loop, emit.
// Depends on rlpst_pkg for the state, command and status types.
`default_nettype none

module rlpst_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rlpst_pkg::stat_t stat,
    output rlpst_pkg::cmd_t       cmd
);

    rlpst_pkg::state_t state_reg;
    rlpst_pkg::state_t state_next;
    logic              emit_now;

    // A result can leave once no list closes at the current top and the output is free.
    assign emit_now = (state_reg == rlpst_pkg::ST_POP) && !stat.pop_hit && !stat.out_busy;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlpst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rlpst_pkg::ST_EXEC;
                end
            end
            rlpst_pkg::ST_EXEC:
            begin
                state_next = rlpst_pkg::ST_POP;
            end
            rlpst_pkg::ST_POP:
            begin
                if (stat.pop_hit)
                begin
                    state_next = rlpst_pkg::ST_FETCH;
                end
                else if (!stat.out_busy)
                begin
                    state_next = in_valid ? rlpst_pkg::ST_EXEC : rlpst_pkg::ST_IDLE;
                end
            end
            rlpst_pkg::ST_FETCH:
            begin
                state_next = rlpst_pkg::ST_POP;
            end
            default:
            begin
                state_next = rlpst_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        in_ready     = (state_reg == rlpst_pkg::ST_IDLE) || emit_now;
        cmd.capture  = in_valid && in_ready;
        cmd.exec     = (state_reg == rlpst_pkg::ST_EXEC);
        cmd.pop      = (state_reg == rlpst_pkg::ST_POP) && stat.pop_hit;
        cmd.emit     = emit_now;
        cmd.load_top = (state_reg == rlpst_pkg::ST_FETCH);
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlpst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rlpst_dpath.sv @@
// Datapath of the tokenizer: parse state, length accumulation, span checks,
// the list end stack with its cached top entry, and the output register.
// Depends on rlpst_pkg and instantiates rlpst_ram for the stack.
`default_nettype none

module rlpst_dpath #(
    parameter int MAX_DEPTH     = rlpst_pkg::DEF_MAX_DEPTH,
    parameter int MAX_LEN_BYTES = rlpst_pkg::DEF_MAX_LEN_BYTES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rlpst_pkg::cmd_t                cmd,
    output rlpst_pkg::stat_t                    stat,
    input  wire logic [rlpst_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                           message_end,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [rlpst_pkg::KIND_W-1:0]        byte_kind,
    output logic [rlpst_pkg::LEVEL_W-1:0]       nest_level,
    output logic [rlpst_pkg::LEN_W-1:0]         item_length,
    output logic                                length_valid,
    output logic [rlpst_pkg::CLOSED_W-1:0]      lists_closed,
    output logic [rlpst_pkg::ERR_W-1:0]         error_code,
    output logic                                end_seen
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW = $clog2(MAX_LEN_BYTES + 1);
    localparam int LEN_W = rlpst_pkg::LEN_W;

    // Captured input beat.
    logic [rlpst_pkg::DATA_W-1:0] byte_reg;
    logic                         end_reg;

    // Parse state.
    rlpst_pkg::phase_t   phase_reg;
    logic                pend_list_reg;
    logic [LW-1:0]       left_reg;
    logic [LEN_W-1:0]    acc_reg;
    logic [LEN_W-1:0]    pay_reg;
    logic [LEN_W-1:0]    pos_reg;
    logic [CW-1:0]       open_reg;
    logic [LEN_W-1:0]    top_reg;
    rlpst_pkg::err_t     err_reg;

    // Result under construction.
    rlpst_pkg::kind_t               res_kind_reg;
    logic [rlpst_pkg::LEVEL_W-1:0]  res_nest_reg;
    logic [LEN_W-1:0]               res_len_reg;
    logic                           res_valid_reg;
    logic [rlpst_pkg::CLOSED_W-1:0] res_closed_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [rlpst_pkg::KIND_W-1:0]   out_kind_reg;
    logic [rlpst_pkg::LEVEL_W-1:0]  out_nest_reg;
    logic [LEN_W-1:0]               out_len_reg;
    logic                           out_lvalid_reg;
    logic [rlpst_pkg::CLOSED_W-1:0] out_closed_reg;
    logic [rlpst_pkg::ERR_W-1:0]    out_err_reg;
    logic                           out_end_reg;

    // Execute-step results.
    rlpst_pkg::phase_t     x_phase;
    logic                  x_pend;
    logic [LW-1:0]         x_left;
    logic [LEN_W-1:0]      x_acc;
    logic [LEN_W-1:0]      x_pay;
    logic [CW-1:0]         x_open;
    logic [LEN_W-1:0]      x_top;
    rlpst_pkg::err_t       x_err;
    rlpst_pkg::kind_t      x_kind;
    logic [LEN_W-1:0]      x_len;
    logic                  x_valid;
    logic                  x_push;
    logic                  do_open;
    logic                  open_list;
    logic                  do_long;
    logic                  long_list;
    logic [rlpst_pkg::NB_W-1:0] nb;
    logic [LEN_W-1:0]      span_len;
    logic [LEN_W:0]        span_end;
    logic                  span_bad;

    // Other datapath signals.
    logic [CW+3:0]                 open_ext;
    logic [rlpst_pkg::LEVEL_W-1:0] nest_sat;
    logic [CW-1:0]                 pop_idx;
    logic                          pop_hit;
    logic                          out_busy;
    rlpst_pkg::err_t               emit_err;
    logic [LEN_W-1:0]              ram_rdata;
    logic                          ram_we;

    // Span end of the item whose header is being decoded, and the overrun check.
    always_comb
    begin
        span_end = {1'b0, pos_reg} + {1'b0, span_len};
        span_bad = span_end[LEN_W] || ((open_reg != '0) && (span_end[LEN_W-1:0] > top_reg));
    end

    // Execute step: classify the byte and update the parse state.
    always_comb
    begin
        x_phase   = phase_reg;
        x_pend    = pend_list_reg;
        x_left    = left_reg;
        x_acc     = acc_reg;
        x_pay     = pay_reg;
        x_open    = open_reg;
        x_top     = top_reg;
        x_err     = rlpst_pkg::ERR_NONE;
        x_kind    = rlpst_pkg::KIND_PAYLOAD;
        x_len     = '0;
        x_valid   = 1'b0;
        x_push    = 1'b0;
        do_open   = 1'b0;
        open_list = 1'b0;
        do_long   = 1'b0;
        long_list = 1'b0;
        nb        = '0;
        span_len  = '0;

        if (err_reg == rlpst_pkg::ERR_NONE)
        begin
            case (phase_reg)
                rlpst_pkg::PH_LENGTH:
                begin
                    x_kind = rlpst_pkg::KIND_LEN_BYTE;
                    if (acc_reg[LEN_W-1:LEN_W-8] != '0)
                    begin
                        x_err = rlpst_pkg::ERR_OVERRUN;
                    end
                    else
                    begin
                        x_acc = {acc_reg[LEN_W-9:0], byte_reg};
                        if (left_reg != '0)
                        begin
                            x_left = left_reg - LW'(1);
                        end
                        if (x_left == '0)
                        begin
                            x_len     = x_acc;
                            x_valid   = 1'b1;
                            x_phase   = rlpst_pkg::PH_PREFIX;
                            do_open   = 1'b1;
                            open_list = pend_list_reg;
                        end
                    end
                end
                rlpst_pkg::PH_PAYLOAD:
                begin
                    if (pay_reg != '0)
                    begin
                        x_pay = pay_reg - LEN_W'(1);
                    end
                    if (x_pay == '0)
                    begin
                        x_phase = rlpst_pkg::PH_PREFIX;
                    end
                end
                default:
                begin
                    x_phase = rlpst_pkg::PH_PREFIX;
                    if (byte_reg < rlpst_pkg::STR_BASE)
                    begin
                        x_kind = rlpst_pkg::KIND_SINGLE;
                    end
                    else if (byte_reg inside {[rlpst_pkg::STR_BASE:rlpst_pkg::STR_SHORT_LAST]})
                    begin
                        x_kind  = rlpst_pkg::KIND_SHORT_STR;
                        x_len   = LEN_W'(byte_reg - rlpst_pkg::STR_BASE);
                        x_valid = 1'b1;
                        do_open = 1'b1;
                    end
                    else if (byte_reg < rlpst_pkg::LIST_BASE)
                    begin
                        x_kind  = rlpst_pkg::KIND_LONG_STR;
                        nb      = rlpst_pkg::NB_W'(byte_reg - rlpst_pkg::STR_SHORT_LAST);
                        do_long = 1'b1;
                    end
                    else if (byte_reg <= rlpst_pkg::LIST_SHORT_LAST)
                    begin
                        x_kind    = rlpst_pkg::KIND_SHORT_LIST;
                        x_len     = LEN_W'(byte_reg - rlpst_pkg::LIST_BASE);
                        x_valid   = 1'b1;
                        do_open   = 1'b1;
                        open_list = 1'b1;
                    end
                    else
                    begin
                        x_kind    = rlpst_pkg::KIND_LONG_LIST;
                        nb        = rlpst_pkg::NB_W'(byte_reg - rlpst_pkg::LIST_SHORT_LAST);
                        do_long   = 1'b1;
                        long_list = 1'b1;
                    end
                end
            endcase

            span_len = do_long ? LEN_W'(nb) : x_len;

            // Long header: check the length-byte count and that the length bytes fit.
            if (do_long)
            begin
                if (nb > rlpst_pkg::NB_W'(MAX_LEN_BYTES))
                begin
                    x_err = rlpst_pkg::ERR_LONGLEN;
                end
                else if (span_bad)
                begin
                    x_err = rlpst_pkg::ERR_OVERRUN;
                end
                else
                begin
                    x_phase = rlpst_pkg::PH_LENGTH;
                    x_left  = LW'(nb);
                    x_acc   = '0;
                    x_pend  = long_list;
                end
            end

            // Completed header: open a string payload or push a list end.
            if (do_open)
            begin
                if (span_bad)
                begin
                    x_err = rlpst_pkg::ERR_OVERRUN;
                end
                else if (x_len != '0)
                begin
                    if (open_list)
                    begin
                        if (open_reg >= CW'(MAX_DEPTH))
                        begin
                            x_err = rlpst_pkg::ERR_DEEP;
                        end
                        else
                        begin
                            x_push = 1'b1;
                            x_open = open_reg + CW'(1);
                            x_top  = span_end[LEN_W-1:0];
                        end
                    end
                    else
                    begin
                        x_phase = rlpst_pkg::PH_PAYLOAD;
                        x_pay   = x_len;
                    end
                end
            end
        end
    end

    // Nesting level at the byte, saturated.
    always_comb
    begin
        open_ext = (CW + 4)'(open_reg);
        nest_sat = (open_ext > (CW + 4)'(rlpst_pkg::SAT_MAX)) ? rlpst_pkg::SAT_MAX
                                                              : open_ext[3:0];
    end

    // Stack pop test, output slot status and early-end check.
    always_comb
    begin
        pop_hit  = (open_reg != '0) && (top_reg == pos_reg) &&
                   (err_reg == rlpst_pkg::ERR_NONE);
        out_busy = out_valid_reg && !out_ready;
        pop_idx  = open_reg - CW'(2);
        emit_err = err_reg;
        if ((err_reg == rlpst_pkg::ERR_NONE) && end_reg &&
            ((phase_reg != rlpst_pkg::PH_PREFIX) || (open_reg != '0)))
        begin
            emit_err = rlpst_pkg::ERR_EARLY;
        end
        stat.pop_hit  = pop_hit;
        stat.out_busy = out_busy;
        ram_we        = cmd.exec && x_push;
    end

    // List end stack; the top entry is also held in top_reg.
    rlpst_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (open_reg[AW-1:0]),
        .wdata (span_end[LEN_W-1:0]),
        .raddr (pop_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Captured beat and stack top copy.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= data_byte;
            end_reg  <= message_end;
        end
        if (cmd.exec)
        begin
            top_reg <= x_top;
        end
        else if (cmd.load_top)
        begin
            top_reg <= ram_rdata;
        end
    end

    // Parse state: execute step, pops, position advance, and restart at the message end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rlpst_pkg::PH_PREFIX;
            pend_list_reg <= 1'b0;
            left_reg      <= '0;
            acc_reg       <= '0;
            pay_reg       <= '0;
            pos_reg       <= '0;
            open_reg      <= '0;
            err_reg       <= rlpst_pkg::ERR_NONE;
        end
        else if (cmd.exec)
        begin
            phase_reg     <= x_phase;
            pend_list_reg <= x_pend;
            left_reg      <= x_left;
            acc_reg       <= x_acc;
            pay_reg       <= x_pay;
            open_reg      <= x_open;
            if (x_err != rlpst_pkg::ERR_NONE)
            begin
                err_reg <= x_err;
            end
        end
        else if (cmd.pop)
        begin
            open_reg <= open_reg - CW'(1);
        end
        else if (cmd.emit)
        begin
            if (end_reg)
            begin
                phase_reg     <= rlpst_pkg::PH_PREFIX;
                pend_list_reg <= 1'b0;
                left_reg      <= '0;
                acc_reg       <= '0;
                pay_reg       <= '0;
                pos_reg       <= '0;
                open_reg      <= '0;
                err_reg       <= rlpst_pkg::ERR_NONE;
            end
            else
            begin
                pos_reg <= pos_reg + LEN_W'(1);
            end
        end
    end

    // Result fields gathered over the execute step and the pop loop.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_kind_reg   <= x_kind;
            res_nest_reg   <= nest_sat;
            res_len_reg    <= x_len;
            res_valid_reg  <= x_valid;
            res_closed_reg <= '0;
        end
        else if (cmd.pop && (res_closed_reg != rlpst_pkg::SAT_MAX))
        begin
            res_closed_reg <= res_closed_reg + rlpst_pkg::CLOSED_W'(1);
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg   <= res_kind_reg;
            out_nest_reg   <= res_nest_reg;
            out_len_reg    <= res_len_reg;
            out_lvalid_reg <= res_valid_reg;
            out_closed_reg <= res_closed_reg;
            out_err_reg    <= emit_err;
            out_end_reg    <= end_reg;
        end
    end

    // Output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_kind    = out_kind_reg;
    assign nest_level   = out_nest_reg;
    assign item_length  = out_len_reg;
    assign length_valid = out_lvalid_reg;
    assign lists_closed = out_closed_reg;
    assign error_code   = out_err_reg;
    assign end_seen     = out_end_reg;

    // The open list count never passes the stack depth.
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= CW'(MAX_DEPTH))
        else $error("open list count exceeds the stack depth");

    // A pop is only commanded when the cached top closes at this byte.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> pop_hit)
        else $error("stack pop without a matching list end");

    // A result is never written over one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_busy)
        else $error("output register overwritten while held");

    // After the last byte of a message the parse state is back at its start.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && end_reg) |=> (pos_reg == '0) && (open_reg == '0) &&
                                  (err_reg == rlpst_pkg::ERR_NONE))
        else $error("state not restarted after message end");

    // A recorded error holds until the message ends.
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != rlpst_pkg::ERR_NONE) && !(cmd.emit && end_reg)) |=>
            (err_reg == $past(err_reg)))
        else $error("sticky error changed inside a message");

endmodule

`default_nettype wire

@@ design/rlp_stream_tokenizer_core.sv @@
// RLP stream tokenizer, top level. Takes one encoded byte per input beat and gives one
// token result beat per byte. A byte is decoded and span-checked in the execute step;
// then each list whose last byte it is gets popped from the list end stack, whose
// registered-read memory supplies the next top entry in the following cycle. Once the
// stack-top compare finds no more lists to close, the result is handed to the output
// register as soon as that is free. The next byte is taken in the same cycle as a
// result enters the output register, so a result waiting there holds up at most the
// following byte. No clearing pass follows reset. Depends on rlpst_pkg, rlpst_if,
// rlpst_ram, rlpst_ctrl and rlpst_dpath.
`default_nettype none

module rlp_stream_tokenizer_core #(
    parameter int MAX_DEPTH     = rlpst_pkg::DEF_MAX_DEPTH,
    parameter int MAX_LEN_BYTES = rlpst_pkg::DEF_MAX_LEN_BYTES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rlpst_in_if.sink      byte_in,
    rlpst_out_if.source   token_out
);

    rlpst_pkg::cmd_t  cmd;
    rlpst_pkg::stat_t stat;
    logic             in_ready;

    assign byte_in.ready = in_ready;

    // Sequencer.
    rlpst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Decode datapath with the list end stack and the output register.
    rlpst_dpath #(
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (byte_in.data_byte),
        .message_end  (byte_in.message_end),
        .out_ready    (token_out.ready),
        .out_valid    (token_out.valid),
        .byte_kind    (token_out.byte_kind),
        .nest_level   (token_out.nest_level),
        .item_length  (token_out.item_length),
        .length_valid (token_out.length_valid),
        .lists_closed (token_out.lists_closed),
        .error_code   (token_out.error_code),
        .end_seen     (token_out.end_seen)
    );

endmodule

`default_nettype wire
